/* design/cur_pkg.sv */
package cur_pkg;

	localparam int EVENT_WIDTH_DEF = 32;
	localparam logic [3:0] RETRY_LIMIT_RST = 4'd5;
	localparam logic [15:0] TIMEOUT_TICKS_RST = 16'd5000;
	localparam int CFG_DATA_WIDTH = 16;

	typedef enum logic [1:0] {
		MODE_START = 2'd0,
		MODE_RESP = 2'd1,
		MODE_TICK = 2'd2,
		MODE_NONE = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		KIND_NONE = 2'd0,
		KIND_CONFIRM = 2'd1,
		KIND_INDICATE = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		CODE_SUCCESS = 2'd0,
		CODE_BUSY = 2'd1,
		CODE_FAILURE = 2'd2,
		CODE_WRONG_MODE = 2'd3
	} code_t;

	typedef enum logic {
		REG_RETRY_LIMIT = 1'b0,
		REG_TIMEOUT_TICKS = 1'b1
	} reg_idx_t;

endpackage

/* design/chunked_upload_retry_session.sv */
// Stop-and-wait requester for an indexed upload session.
// Input stream (s_*): one item per request. s_tuser carries the item kind
// (start request, partner response or timer tick) and s_tdata carries the
// message fields together with the storage status sampled for that item.
// Output stream (m_*): zero, one or two results per input item. m_tuser is
// the message kind, m_tdata holds the confirmation code, indexes and storage
// controls, and m_tlast marks the final result of an input item.
// Configuration: retry_limit (index 0) and timeout_ticks (index 1) are written
// through cfg_we/cfg_index/cfg_data; the user must write them only while the
// block is idle, and the block itself does not enforce this.
// Timing: an accepted item sits in the input register, where its results are
// computed and written into a four-entry result queue, from which they are
// offered. One item is taken per cycle as long as the queue holds two or
// fewer results, so the rate is set by how fast the receiver drains the
// queue: a start request that succeeds yields two results.
// When the receiver stalls, results wait in the queue and the input stops
// once the queue cannot take another two results.
// Reset: arst_n clears the session, the timer, the queue and restores the
// retry limit to 5 and the timeout to 5000 ticks.
module chunked_upload_retry_session #(
	parameter int EVENT_WIDTH = cur_pkg::EVENT_WIDTH_DEF,
	localparam int IN_BITS = 34 + EVENT_WIDTH,
	localparam int IN_WIDTH = ((IN_BITS + 7) / 8) * 8,
	localparam int OUT_BITS = 37 + EVENT_WIDTH,
	localparam int OUT_WIDTH = ((OUT_BITS + 7) / 8) * 8
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// msg_index, msg_last, msg_event, storage_status
	input  logic [IN_WIDTH-1:0]                s_tdata,
	// mode
	input  logic [1:0]                         s_tuser,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// result_code, out_index, out_last, store_start, store_push,
	// store_event, store_stop
	output logic [OUT_WIDTH-1:0]               m_tdata,
	// msg_kind
	output logic [1:0]                         m_tuser,
	output logic                               m_tlast,
	input  logic                               cfg_we,
	input  logic                               cfg_index,
	input  logic [cur_pkg::CFG_DATA_WIDTH-1:0] cfg_data
);
	import cur_pkg::*;

	typedef struct packed {
		kind_t                  kind;
		code_t                  code;
		logic [15:0]            idx;
		logic [15:0]            last;
		logic                   start;
		logic                   push;
		logic [EVENT_WIDTH-1:0] event_w;
		logic                   stop;
		logic                   tlast;
	} res_t;

	localparam int QDEPTH = 4;

	// Configuration registers.
	logic [3:0]  retry_limit_q;
	logic [15:0] timeout_ticks_q;

	// Input register.
	logic                   s1_valid_s1;
	mode_t                  mode_s1;
	logic [15:0]            msg_index_s1;
	logic [15:0]            msg_last_s1;
	logic [EVENT_WIDTH-1:0] msg_event_s1;
	code_t                  st_code_s1;

	// Session state.
	logic        session_active_q;
	logic [15:0] expected_index_q;
	logic [15:0] last_index_q;
	logic [3:0]  retry_count_q;
	logic        timer_armed_q;
	logic [15:0] timer_left_q;

	// Result queue.
	res_t       res_q [QDEPTH];
	logic [1:0] wr_ptr_q;
	logic [1:0] rd_ptr_q;
	logic [2:0] cnt_q;

	logic        proc;
	logic        pop;
	logic [1:0]  n_res;
	res_t        r0;
	res_t        r1;
	logic        nxt_active;
	logic [15:0] nxt_expected;
	logic [15:0] nxt_last;
	logic [3:0]  nxt_retry;
	logic        nxt_armed;
	logic [15:0] nxt_left;
	logic [3:0]  rc_inc;
	logic        retry_ok;
	logic        idx_match;
	logic [15:0] exp_inc;
	logic [1:0]  st_in;
	logic [2:0]  n_push;

	assign proc = s1_valid_s1 && (cnt_q <= 3'd2);
	assign s_tready = !s1_valid_s1 || proc;
	assign pop = m_tvalid && m_tready;
	assign st_in = s_tdata[33+EVENT_WIDTH:32+EVENT_WIDTH];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			retry_limit_q <= RETRY_LIMIT_RST;
			timeout_ticks_q <= TIMEOUT_TICKS_RST;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_RETRY_LIMIT: retry_limit_q <= cfg_data[3:0];
				REG_TIMEOUT_TICKS: timeout_ticks_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
		end else if (s_tready) begin
			s1_valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			mode_s1 <= mode_t'(s_tuser);
			msg_index_s1 <= s_tdata[15:0];
			msg_last_s1 <= s_tdata[31:16];
			msg_event_s1 <= s_tdata[32+EVENT_WIDTH-1:32];
			st_code_s1 <= (st_in[1]) ? CODE_FAILURE : code_t'(st_in);
		end
	end

	assign rc_inc = retry_count_q + 4'd1;
	assign retry_ok = rc_inc < retry_limit_q;
	assign idx_match = (msg_index_s1 == expected_index_q) && (msg_last_s1 == last_index_q);
	assign exp_inc = expected_index_q + 16'd1;

	always_comb begin
		nxt_active = session_active_q;
		nxt_expected = expected_index_q;
		nxt_last = last_index_q;
		nxt_retry = retry_count_q;
		nxt_armed = timer_armed_q;
		nxt_left = timer_left_q;
		r0 = '0;
		r1 = '0;
		n_res = 2'd0;
		unique case (mode_s1)
			MODE_START: begin
				n_res = 2'd1;
				r0.kind = KIND_CONFIRM;
				r0.last = msg_last_s1;
				if (!session_active_q) begin
					nxt_active = 1'b1;
					nxt_expected = 16'd0;
					nxt_last = msg_last_s1;
					r0.code = st_code_s1;
					r0.start = 1'b1;
					if (st_code_s1 == CODE_SUCCESS) begin
						n_res = 2'd2;
						r1.kind = KIND_INDICATE;
						r1.last = msg_last_s1;
						nxt_retry = 4'd0;
						nxt_armed = 1'b1;
						nxt_left = timeout_ticks_q;
					end
				end else begin
					r0.code = CODE_WRONG_MODE;
				end
			end
			MODE_RESP: begin
				n_res = 2'd1;
				nxt_armed = 1'b0;
				if (!session_active_q) begin
					r0.kind = KIND_CONFIRM;
					r0.code = CODE_WRONG_MODE;
					r0.last = last_index_q;
					r0.stop = 1'b1;
					nxt_retry = 4'd0;
					nxt_active = 1'b0;
				end else if (idx_match) begin
					r0.push = 1'b1;
					r0.event_w = msg_event_s1;
					if (st_code_s1 != CODE_SUCCESS) begin
						r0.kind = KIND_CONFIRM;
						r0.code = st_code_s1;
						r0.last = last_index_q;
					end else if (expected_index_q < last_index_q) begin
						nxt_expected = exp_inc;
						nxt_retry = 4'd0;
						r0.kind = KIND_INDICATE;
						r0.idx = exp_inc;
						r0.last = last_index_q;
						nxt_armed = 1'b1;
						nxt_left = timeout_ticks_q;
					end else begin
						if (expected_index_q != last_index_q) begin
							nxt_expected = exp_inc;
						end
						r0.stop = 1'b1;
						nxt_retry = 4'd0;
						nxt_active = 1'b0;
					end
				end else begin
					nxt_retry = rc_inc;
					r0.last = last_index_q;
					if (retry_ok) begin
						r0.kind = KIND_INDICATE;
						r0.idx = expected_index_q;
						nxt_armed = 1'b1;
						nxt_left = timeout_ticks_q;
					end else begin
						r0.kind = KIND_CONFIRM;
						r0.code = CODE_FAILURE;
						r0.stop = 1'b1;
						nxt_retry = 4'd0;
						nxt_active = 1'b0;
					end
				end
			end
			MODE_TICK: begin
				if (timer_armed_q) begin
					if (timer_left_q <= 16'd1) begin
						n_res = 2'd1;
						nxt_armed = 1'b0;
						nxt_left = 16'd0;
						if (expected_index_q == last_index_q) begin
							r0.stop = 1'b1;
							nxt_retry = 4'd0;
							nxt_active = 1'b0;
						end else begin
							nxt_retry = rc_inc;
							r0.last = last_index_q;
							if (retry_ok) begin
								r0.kind = KIND_INDICATE;
								r0.idx = expected_index_q;
								nxt_armed = 1'b1;
								nxt_left = timeout_ticks_q;
							end else begin
								r0.kind = KIND_CONFIRM;
								r0.code = CODE_FAILURE;
								r0.stop = 1'b1;
								nxt_retry = 4'd0;
								nxt_active = 1'b0;
							end
						end
					end else begin
						nxt_left = timer_left_q - 16'd1;
					end
				end
			end
			default: ;
		endcase
		if (n_res == 2'd2) begin
			r1.tlast = 1'b1;
		end else begin
			r0.tlast = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			session_active_q <= 1'b0;
			expected_index_q <= 16'd0;
			last_index_q <= 16'd0;
			retry_count_q <= 4'd0;
			timer_armed_q <= 1'b0;
			timer_left_q <= 16'd0;
		end else if (proc) begin
			session_active_q <= nxt_active;
			expected_index_q <= nxt_expected;
			last_index_q <= nxt_last;
			retry_count_q <= nxt_retry;
			timer_armed_q <= nxt_armed;
			timer_left_q <= nxt_left;
		end
	end

	assign n_push = proc ? {1'b0, n_res} : 3'd0;

	always_ff @(posedge clk) begin
		if (proc && n_res != 2'd0) begin
			res_q[wr_ptr_q] <= r0;
			if (n_res == 2'd2) begin
				res_q[wr_ptr_q + 2'd1] <= r1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 2'd0;
			rd_ptr_q <= 2'd0;
			cnt_q <= 3'd0;
		end else begin
			wr_ptr_q <= wr_ptr_q + n_push[1:0];
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 2'd1;
			end
			cnt_q <= cnt_q + n_push - {2'b00, pop};
		end
	end

	assign m_tvalid = (cnt_q != 3'd0);
	assign m_tuser = res_q[rd_ptr_q].kind;
	assign m_tlast = res_q[rd_ptr_q].tlast;
	always_comb begin
		m_tdata = '0;
		m_tdata[1:0] = res_q[rd_ptr_q].code;
		m_tdata[17:2] = res_q[rd_ptr_q].idx;
		m_tdata[33:18] = res_q[rd_ptr_q].last;
		m_tdata[34] = res_q[rd_ptr_q].start;
		m_tdata[35] = res_q[rd_ptr_q].push;
		m_tdata[36+EVENT_WIDTH-1:36] = res_q[rd_ptr_q].event_w;
		m_tdata[36+EVENT_WIDTH] = res_q[rd_ptr_q].stop;
	end

`ifndef SYNTH
	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 3'd4)
		else $error("result queue count exceeds its depth");

	a_queue_count: assert property (@(posedge clk) disable iff (!arst_n)
		$past(arst_n) |-> cnt_q == $past(cnt_q) + $past(n_push) - {2'b00, $past(pop)})
		else $error("result queue count does not track pushes and pops");

	a_timer_in_session: assert property (@(posedge clk) disable iff (!arst_n)
		timer_armed_q |-> session_active_q)
		else $error("timer armed outside a session");

	a_start_two: assert property (@(posedge clk) disable iff (!arst_n)
		proc && mode_s1 == MODE_START && !session_active_q && st_code_s1 == CODE_SUCCESS
		|=> session_active_q && timer_armed_q && retry_count_q == 4'd0)
		else $error("successful start did not open an armed session");
`endif

endmodule
